// ===== src/iovaw_pkg.sv =====
// Package for the two-level IOVA page walker.
// Holds the item structs, walk phase type, result and fault codes and default sizes.
// No dependencies.
package iovaw_pkg;

  // Fixed field widths of the items
  localparam int unsigned VA_W   = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 44;

  // Each table entry is four bytes wide
  localparam int unsigned ENTRY_SHIFT = 2;

  // Default geometry of the address split
  localparam int unsigned DEF_FIRST_INDEX_BITS  = 10;
  localparam int unsigned DEF_SECOND_INDEX_BITS = 10;
  localparam int unsigned DEF_PAGE_OFFSET_BITS  = 12;
  localparam int unsigned DEF_FRAME_SHIFT       = 12;

  // Request types
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_RESPONSE  = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // Fault codes
  localparam logic [2:0] FAULT_NONE       = 3'd0;
  localparam logic [2:0] FAULT_ROOT_UNSET = 3'd1;
  localparam logic [2:0] FAULT_L1         = 3'd2;
  localparam logic [2:0] FAULT_L2         = 3'd3;
  localparam logic [2:0] FAULT_UNEXPECTED = 3'd4;

  // Walk phase
  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_L1   = 2'd1,
    PHASE_L2   = 2'd2
  } walk_phase_t;

  // Input item
  typedef struct packed {
    logic              req_type;
    logic [VA_W-1:0]   virt_addr;
    logic [DATA_W-1:0] read_data;
    logic              read_error;
  } walk_in_t;

  // Result item
  typedef struct packed {
    logic [1:0]        result_kind;
    logic [ADDR_W-1:0] phys_addr;
    logic [2:0]        fault_code;
  } walk_out_t;

endpackage

// ===== src/two_level_iova_page_walker.sv =====
// Top level of the two-level IOVA page walker: input register, walk state, result register.
// Depends on iovaw_pkg and iovaw_step.
//
//   Channel | Ports                              | Direction | Moves
//   --------+------------------------------------+-----------+------------------------------
//   in      | in_valid, in_ready, in_item        | to block  | request or read response item
//   out     | out_valid, out_ready, out_item     | from block| read, done or fault item
//   cfg     | cfg_we, cfg_wdata                  | to block  | root table frame number
//
// One item is accepted per cycle while the output is not stalled; each result is registered in
// the result register as its item leaves the input register. The input register and the result
// register form a two-stage pipeline, and the walk state is updated as an item moves from the first to the second.
// Reset clears both valid flags, the walk phase, the saved second index and page offset, and the root register.
// While out_ready is low the result holds; the input register takes one more item, then stalls.
module two_level_iova_page_walker
  import iovaw_pkg::*;
#(
  parameter int unsigned FIRST_INDEX_BITS  = DEF_FIRST_INDEX_BITS,
  parameter int unsigned SECOND_INDEX_BITS = DEF_SECOND_INDEX_BITS,
  parameter int unsigned PAGE_OFFSET_BITS  = DEF_PAGE_OFFSET_BITS,
  parameter int unsigned FRAME_SHIFT       = DEF_FRAME_SHIFT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  walk_in_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output walk_out_t         out_item,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  logic                         in_valid_r;
  walk_in_t                     in_item_r;
  logic                         out_valid_r;
  walk_out_t                    out_item_r;
  logic [DATA_W-1:0]            root_pfn_r;
  walk_phase_t                  phase_r;
  logic [SECOND_INDEX_BITS-1:0] second_idx_r;
  logic [PAGE_OFFSET_BITS-1:0]  pg_ofs_r;

  walk_out_t                    out_item_nxt;
  walk_phase_t                  phase_nxt;
  logic [SECOND_INDEX_BITS-1:0] second_idx_nxt;
  logic [PAGE_OFFSET_BITS-1:0]  pg_ofs_nxt;
  logic                         advance;
  logic                         step_en;

  // The result register can take a new item when empty or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign step_en  = in_valid_r && advance;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Walk step logic
  iovaw_step #(
    .FIRST_INDEX_BITS (FIRST_INDEX_BITS),
    .SECOND_INDEX_BITS(SECOND_INDEX_BITS),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS),
    .FRAME_SHIFT      (FRAME_SHIFT)
  ) u_step (
    .item          (in_item_r),
    .phase         (phase_r),
    .root_pfn      (root_pfn_r),
    .second_idx    (second_idx_r),
    .pg_ofs        (pg_ofs_r),
    .result        (out_item_nxt),
    .phase_nxt     (phase_nxt),
    .second_idx_nxt(second_idx_nxt),
    .pg_ofs_nxt    (pg_ofs_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Walk state, updated as each item passes through the step logic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PHASE_IDLE;
      second_idx_r <= '0;
      pg_ofs_r     <= '0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      second_idx_r <= second_idx_nxt;
      pg_ofs_r     <= pg_ofs_nxt;
    end
  end

  // Root table register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_pfn_r <= '0;
    end else if (cfg_we) begin
      root_pfn_r <= cfg_wdata;
    end
  end

endmodule

// ===== src/iovaw_step.sv =====
// Combinational walk step: turns one item and the current walk state into a result
// and the next walk state. Depends on iovaw_pkg.
module iovaw_step
  import iovaw_pkg::*;
#(
  parameter int unsigned FIRST_INDEX_BITS  = DEF_FIRST_INDEX_BITS,
  parameter int unsigned SECOND_INDEX_BITS = DEF_SECOND_INDEX_BITS,
  parameter int unsigned PAGE_OFFSET_BITS  = DEF_PAGE_OFFSET_BITS,
  parameter int unsigned FRAME_SHIFT       = DEF_FRAME_SHIFT
) (
  input  walk_in_t                     item,
  input  walk_phase_t                  phase,
  input  logic [DATA_W-1:0]            root_pfn,
  input  logic [SECOND_INDEX_BITS-1:0] second_idx,
  input  logic [PAGE_OFFSET_BITS-1:0]  pg_ofs,
  output walk_out_t                    result,
  output walk_phase_t                  phase_nxt,
  output logic [SECOND_INDEX_BITS-1:0] second_idx_nxt,
  output logic [PAGE_OFFSET_BITS-1:0]  pg_ofs_nxt
);

  logic [VA_W-1:0]              va_hi;
  logic [VA_W-1:0]              va_mid;
  logic [FIRST_INDEX_BITS-1:0]  first_idx;
  logic [SECOND_INDEX_BITS-1:0] va_second;
  logic [PAGE_OFFSET_BITS-1:0]  va_off;
  logic [ADDR_W-1:0]            l1_addr;
  logic [ADDR_W-1:0]            l2_addr;
  logic [ADDR_W-1:0]            final_addr;
  logic                         entry_bad;

  // Split the virtual address into its two indexes and the page offset
  assign va_hi     = item.virt_addr >> (SECOND_INDEX_BITS + PAGE_OFFSET_BITS);
  assign va_mid    = item.virt_addr >> PAGE_OFFSET_BITS;
  assign first_idx = va_hi[FIRST_INDEX_BITS-1:0];
  assign va_second = va_mid[SECOND_INDEX_BITS-1:0];
  assign va_off    = item.virt_addr[PAGE_OFFSET_BITS-1:0];

  // Entry and final addresses, all kept to the address width
  assign l1_addr    = (ADDR_W'(root_pfn) << FRAME_SHIFT) +
                      (ADDR_W'(first_idx) << ENTRY_SHIFT);
  assign l2_addr    = (ADDR_W'(item.read_data) << FRAME_SHIFT) +
                      (ADDR_W'(second_idx) << ENTRY_SHIFT);
  assign final_addr = (ADDR_W'(item.read_data) << FRAME_SHIFT) + ADDR_W'(pg_ofs);

  // A failed read or an empty entry ends the walk
  assign entry_bad = item.read_error || (item.read_data == '0);

  // Phase decision
  always_comb begin
    result.result_kind = KIND_FAULT;
    result.phys_addr   = '0;
    result.fault_code  = FAULT_UNEXPECTED;
    phase_nxt          = phase;
    second_idx_nxt     = second_idx;
    pg_ofs_nxt         = pg_ofs;
    unique case (phase)
      PHASE_L1: begin
        if (item.req_type == REQ_RESPONSE) begin
          if (entry_bad) begin
            result.fault_code = FAULT_L1;
            phase_nxt         = PHASE_IDLE;
          end else begin
            result.result_kind = KIND_READ;
            result.phys_addr   = l2_addr;
            result.fault_code  = FAULT_NONE;
            phase_nxt          = PHASE_L2;
          end
        end
      end
      PHASE_L2: begin
        if (item.req_type == REQ_RESPONSE) begin
          phase_nxt = PHASE_IDLE;
          if (entry_bad) begin
            result.fault_code = FAULT_L2;
          end else begin
            result.result_kind = KIND_DONE;
            result.phys_addr   = final_addr;
            result.fault_code  = FAULT_NONE;
          end
        end
      end
      default: begin
        // Idle: only a translate request is expected
        if (item.req_type == REQ_TRANSLATE) begin
          if (root_pfn == '0) begin
            result.fault_code = FAULT_ROOT_UNSET;
          end else begin
            result.result_kind = KIND_READ;
            result.phys_addr   = l1_addr;
            result.fault_code  = FAULT_NONE;
            phase_nxt          = PHASE_L1;
            second_idx_nxt     = va_second;
            pg_ofs_nxt         = va_off;
          end
        end
      end
    endcase
  end

endmodule

// ===== tb/two_level_iova_page_walker_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the two-level IOVA page walker: directed walks, then random
// walks under several root settings, with random input gaps and output stalls.
// Depends on iovaw_pkg and two_level_iova_page_walker.
module two_level_iova_page_walker_test;
  import iovaw_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef enum logic [1:0] {
    RX_OPEN   = 2'd0,
    RX_COIN   = 2'd1,
    RX_SPARSE = 2'd2,
    RX_TOGGLE = 2'd3
  } rx_mode_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  walk_in_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  walk_out_t         out_item;
  logic              cfg_we    = 1'b0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  // Items waiting for the driver, and results the walker still owes.
  walk_in_t  walk_items_todo[$];
  walk_out_t walk_results_due[$];

  // Our own copy of the walk state and the root register.
  walk_phase_t                      model_phase;
  logic [DEF_SECOND_INDEX_BITS-1:0] model_second;
  logic [DEF_PAGE_OFFSET_BITS-1:0]  model_offset;
  logic [DATA_W-1:0]                model_root;

  int unsigned items_queued   = 0;
  int unsigned roots_loaded   = 0;
  int unsigned results_seen   = 0;
  int unsigned reads_seen     = 0;
  int unsigned dones_seen     = 0;
  int unsigned faults_seen    = 0;
  int unsigned mismatch_count = 0;
  logic        in_fire        = 1'b0;

  two_level_iova_page_walker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Address of a four-byte table entry within the given frame, wrapped to the address width.
  function automatic logic [ADDR_W-1:0] entry_address(logic [DATA_W-1:0] frame,
                                                      logic [ADDR_W-1:0] index);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(frame) << DEF_FRAME_SHIFT;
    return base + (index << ENTRY_SHIFT);
  endfunction

  // Works out the result of one item and advances the walk state.
  function automatic walk_out_t walk_step(walk_in_t it);
    walk_out_t                       r;
    logic [DEF_FIRST_INDEX_BITS-1:0] first;
    logic                            bad_entry;
    r             = '0;
    r.result_kind = KIND_FAULT;
    r.fault_code  = FAULT_UNEXPECTED;
    bad_entry     = it.read_error || (it.read_data == '0);
    if (it.req_type == REQ_TRANSLATE) begin
      if (model_phase != PHASE_L1 && model_phase != PHASE_L2) begin
        if (model_root == '0) begin
          r.fault_code = FAULT_ROOT_UNSET;
        end else begin
          first        = DEF_FIRST_INDEX_BITS'(it.virt_addr >>
                                               (DEF_SECOND_INDEX_BITS + DEF_PAGE_OFFSET_BITS));
          model_second = DEF_SECOND_INDEX_BITS'(it.virt_addr >> DEF_PAGE_OFFSET_BITS);
          model_offset = DEF_PAGE_OFFSET_BITS'(it.virt_addr);
          model_phase  = PHASE_L1;
          r.result_kind = KIND_READ;
          r.fault_code  = FAULT_NONE;
          r.phys_addr   = entry_address(model_root, ADDR_W'(first));
        end
      end
    end else if (model_phase == PHASE_L1) begin
      if (bad_entry) begin
        model_phase  = PHASE_IDLE;
        r.fault_code = FAULT_L1;
      end else begin
        model_phase   = PHASE_L2;
        r.result_kind = KIND_READ;
        r.fault_code  = FAULT_NONE;
        r.phys_addr   = entry_address(it.read_data, ADDR_W'(model_second));
      end
    end else if (model_phase == PHASE_L2) begin
      model_phase = PHASE_IDLE;
      if (bad_entry) begin
        r.fault_code = FAULT_L2;
      end else begin
        r.result_kind = KIND_DONE;
        r.fault_code  = FAULT_NONE;
        r.phys_addr   = (ADDR_W'(it.read_data) << DEF_FRAME_SHIFT) + ADDR_W'(model_offset);
      end
    end
    return r;
  endfunction

  task automatic flag_field(string field, longint unsigned want, longint unsigned got);
    mismatch_count++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  // Monitor: tracks root writes, predicts each accepted item and checks each result.
  always @(posedge clk) begin
    walk_out_t want;
    in_fire <= in_valid && in_ready;
    if (!rst_n) begin
      model_phase  = PHASE_IDLE;
      model_second = '0;
      model_offset = '0;
      model_root   = '0;
    end else begin
      if (cfg_we) begin
        model_root = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        case (out_item.result_kind)
          KIND_READ: reads_seen++;
          KIND_DONE: dones_seen++;
          default:   faults_seen++;
        endcase
        if (walk_results_due.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result with nothing expected, got kind %0h addr %0h code %0h",
                   $time, out_item.result_kind, out_item.phys_addr, out_item.fault_code);
        end else begin
          want = walk_results_due.pop_front();
          if (out_item.result_kind !== want.result_kind)
            flag_field("result_kind", want.result_kind, out_item.result_kind);
          if (out_item.phys_addr !== want.phys_addr)
            flag_field("phys_addr", want.phys_addr, out_item.phys_addr);
          if (out_item.fault_code !== want.fault_code)
            flag_field("fault_code", want.fault_code, out_item.fault_code);
        end
      end
      if (in_valid && in_ready) begin
        walk_results_due.push_back(walk_step(in_item));
      end
    end
  end

  // Driver: offers queued items in bursts of random length with random gaps between them.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (walk_items_todo.size() != 0) begin
        in_item  <= walk_items_todo.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: changes its stall pattern now and then, and now and then holds off for a long
  // stretch so that the walker fills up and stops taking items.
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 200;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      out_ready    <= 1'b0;
      hold_left    <= 90;
      next_hold_at <= next_hold_at + 500;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(10, 60);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  task automatic offer(logic kind, logic [VA_W-1:0] va, logic [DATA_W-1:0] data, logic err);
    walk_in_t it;
    it.req_type   = kind;
    it.virt_addr  = va;
    it.read_data  = data;
    it.read_error = err;
    walk_items_todo.push_back(it);
    items_queued++;
  endtask

  // A table entry, now and then at the extremes of its range.
  function automatic logic [DATA_W-1:0] pick_frame();
    case ($urandom_range(0, 15))
      0:       return '1;
      1:       return 1;
      default: return $urandom;
    endcase
  endfunction

  // Queues one read response that is good most of the time; broke says the walk ends here.
  task automatic queue_response(output bit broke);
    int unsigned r;
    r = $urandom_range(0, 99);
    broke = 1'b1;
    if (r < 6) begin
      offer(REQ_RESPONSE, $urandom, ($urandom_range(0, 3) == 0) ? '0 : $urandom, 1'b1);
    end else if (r < 11) begin
      offer(REQ_RESPONSE, $urandom, '0, 1'b0);
    end else begin
      offer(REQ_RESPONSE, $urandom, pick_frame(), 1'b0);
      broke = 1'b0;
    end
  endtask

  // A full walk with random content: request, level-1 entry and, unless the walk breaks there, level-2 entry.
  task automatic queue_walk();
    logic [VA_W-1:0] va;
    bit              broke;
    case ($urandom_range(0, 19))
      0:       va = '0;
      1:       va = '1;
      default: va = $urandom;
    endcase
    offer(REQ_TRANSLATE, va, $urandom, 1'($urandom_range(0, 1)));
    queue_response(broke);
    if (!broke) begin
      queue_response(broke);
    end
  endtask

  // Mostly well-formed walks, the rest single items of any kind.
  task automatic run_random(int unsigned count);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < count) begin
      if ($urandom_range(0, 99) < 78) begin
        queue_walk();
      end else begin
        offer(1'($urandom_range(0, 1)), $urandom,
              ($urandom_range(0, 7) == 0) ? '0 : $urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Waits until every queued item is taken and every result has come back.
  task automatic drain();
    while (walk_items_todo.size() != 0 || in_valid || walk_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_root(logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    roots_loaded++;
  endtask

  initial begin
    logic [DATA_W-1:0] roots[6];
    int unsigned       lengths[6];
    roots   = '{32'h1, $urandom, 32'h0, 32'hFFFF_FFFF, $urandom, $urandom_range(1, 255)};
    lengths = '{260, 260, 30, 260, 260, 260};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Before any root is programmed: a request faults, and so does a stray response.
    offer(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    drain();

    // Largest root: full walk with extreme fields and requests arriving mid-walk.
    load_root(32'hFFFF_FFFF);
    offer(REQ_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 1'b0);
    offer(REQ_TRANSLATE, 32'h0, 32'hFFFF_FFFF, 1'b1);
    offer(REQ_RESPONSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    offer(REQ_TRANSLATE, 32'h0000_1000, 32'h1, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    // Level-1 failures: read error, then an empty entry.
    offer(REQ_TRANSLATE, 32'h0, 32'h0, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'h0000_1234, 1'b1);
    offer(REQ_TRANSLATE, 32'h1234_5678, 32'h0, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'h0, 1'b0);
    // Level-2 failures: read error, then an empty entry.
    offer(REQ_TRANSLATE, 32'h8040_2001, 32'h0, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'h1, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'h8000_0000, 1'b1);
    offer(REQ_TRANSLATE, 32'h7FFF_F000, 32'h0, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'h0000_0ABC, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'h0, 1'b0);
    // Leave a walk open, change the root, and finish it: the walk keeps its old root.
    offer(REQ_TRANSLATE, 32'hA5A5_A5A5, 32'h0, 1'b0);
    drain();
    load_root(32'h1);
    offer(REQ_RESPONSE, 32'h0, 32'h0000_0001, 1'b0);
    offer(REQ_RESPONSE, 32'h0, 32'hFFFF_FFFE, 1'b0);
    drain();

    // Random walks under a run of root settings; a walk may be left open across a change.
    foreach (roots[i]) begin
      load_root(roots[i]);
      run_random(lengths[i]);
      drain();
    end

    if (walk_results_due.size() != 0)
      $display("%0d results never arrived", walk_results_due.size());
    $display("Covered %0d items under %0d root settings: %0d entry reads, %0d translations,",
             items_queued, roots_loaded, reads_seen, dones_seen);
    $display("and %0d faults, with %0d mismatches.", faults_seen, mismatch_count);
    if (mismatch_count == 0 && walk_results_due.size() == 0) begin
      $display("two_level_iova_page_walker_test: clean");
    end else begin
      $display("two_level_iova_page_walker_test: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run did not finish within %0d ns", RUN_LIMIT_NS);
    $display("two_level_iova_page_walker_test: errors");
    $finish;
  end

endmodule

// ===== files.f =====
src/iovaw_pkg.sv
src/iovaw_step.sv
src/two_level_iova_page_walker.sv
tb/two_level_iova_page_walker_test.sv
